>>> rtl/core/nau_pkg.sv
// Shared types and codes for the NAL access unit merger.
// Used by every module in rtl/core; depends on nothing.
`default_nettype none

package nau_pkg;

	// Register indexes on the configuration port
	localparam logic REG_MERGE_MODE  = 1'b0;
	localparam logic REG_CACHE_LIMIT = 1'b1;

	// merge_mode codes (code 3 behaves as raw)
	localparam logic [1:0] MODE_RAW           = 2'd0;
	localparam logic [1:0] MODE_START_CODE    = 2'd1;
	localparam logic [1:0] MODE_LENGTH_PREFIX = 2'd2;

	// Input command codes
	localparam logic CMD_UNIT  = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// result_kind codes
	localparam logic KIND_MERGED = 1'b0;
	localparam logic KIND_PASS   = 1'b1;

	localparam logic [7:0]  CACHE_LIMIT_RESET = 8'd100;
	localparam logic [24:0] PREFIX_BYTES      = 25'd4;
	localparam logic [8:0]  COUNT_MAX         = 9'h1FF;
	localparam logic [31:0] LEN_MAX           = 32'hFFFF_FFFF;

	// One input descriptor
	typedef struct packed {
		logic        command;
		logic        is_h26x;
		logic [31:0] decode_stamp;
		logic [31:0] present_stamp;
		logic [23:0] unit_size;
		logic [2:0]  prefix_length;
		logic        key_unit;
		logic        decodable;
		logic        droppable;
		logic        config_unit;
	} nau_unit_t;

	// One result word
	typedef struct packed {
		logic        result_kind;
		logic [31:0] out_decode_stamp;
		logic [31:0] out_present_stamp;
		logic        out_key;
		logic [8:0]  unit_count;
		logic [31:0] merged_length;
	} nau_result_t;

	// Cache status seen by the top level
	typedef struct packed {
		logic       emit;
		logic [8:0] cached_count;
	} nau_status_t;

endpackage

`default_nettype wire

>>> rtl/core/nal_access_unit_merger.sv
// Top level of the NAL access unit merger: config registers and handshakes.
// Depends on nau_pkg, nau_input_stage, nau_cache, nau_output_stage.
//
// Collects H.264/H.265 NAL unit descriptors and emits one merged access
// unit word (last unit's stamps, OR of key flags, unit count, saturating
// byte length) each time the flush rule of merge_mode fires; descriptors
// of other codecs pass through as key frames, and a flush command empties
// the cache. One descriptor is taken every clock cycle unless the input
// side stalls; the flush decision, length sum and cache update are all
// combinational between the input register and the cache registers. A result
// word is registered in the result register. The input side stalls only when a
// descriptor that produces a result meets a full result register that is
// not being taken. Write configuration only while the block is idle;
// cfg_ready is always high.
`default_nettype none

module nal_access_unit_merger (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,
	// Descriptor channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic        is_h26x,
	input  wire logic [31:0] decode_stamp,
	input  wire logic [31:0] present_stamp,
	input  wire logic [23:0] unit_size,
	input  wire logic [2:0]  prefix_length,
	input  wire logic        key_unit,
	input  wire logic        decodable,
	input  wire logic        droppable,
	input  wire logic        config_unit,
	// Result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             result_kind,
	output logic [31:0]      out_decode_stamp,
	output logic [31:0]      out_present_stamp,
	output logic             out_key,
	output logic [8:0]       unit_count,
	output logic [31:0]      merged_length
);
	import nau_pkg::*;

	logic [1:0]  merge_mode_q;
	logic [7:0]  cache_limit_q;
	nau_unit_t   in_unit;
	nau_unit_t   unit_s1;
	logic        valid_s1;
	logic        advance;
	nau_status_t status;
	nau_result_t result_next;
	nau_result_t result_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_mode_q  <= MODE_RAW;
			cache_limit_q <= CACHE_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MERGE_MODE:  merge_mode_q  <= cfg_data[1:0];
				REG_CACHE_LIMIT: cache_limit_q <= cfg_data;
			endcase
		end
	end

	assign in_unit = '{command: command, is_h26x: is_h26x, decode_stamp: decode_stamp,
		present_stamp: present_stamp, unit_size: unit_size,
		prefix_length: prefix_length, key_unit: key_unit, decodable: decodable,
		droppable: droppable, config_unit: config_unit};

	// The held word moves on unless its result would hit a blocked output
	assign advance = valid_s1 && (!status.emit || !out_valid || out_ready);

	nau_input_stage u_input (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_unit  (in_unit),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.unit_s1  (unit_s1)
	);

	nau_cache u_cache (
		.clk         (clk),
		.arst_n      (arst_n),
		.merge_mode  (merge_mode_q),
		.cache_limit (cache_limit_q),
		.advance     (advance),
		.unit_s1     (unit_s1),
		.status      (status),
		.result      (result_next)
	);

	nau_output_stage u_output (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && status.emit),
		.result_in (result_next),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.result_q  (result_q)
	);

	assign result_kind       = result_q.result_kind;
	assign out_decode_stamp  = result_q.out_decode_stamp;
	assign out_present_stamp = result_q.out_present_stamp;
	assign out_key           = result_q.out_key;
	assign unit_count        = result_q.unit_count;
	assign merged_length     = result_q.merged_length;

	// Checks

	// cache never grows past the largest limit plus one
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.cached_count <= 9'd256)
		else $error("cache count out of range");

	// a word that yields a result always lands in the result register
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance && status.emit |=> out_valid)
		else $error("result lost");

	// a held descriptor that does not move on stays held
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("descriptor dropped");

	// every emitted frame holds at least one unit
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> unit_count != 9'd0)
		else $error("empty frame emitted");

endmodule

`default_nettype wire

>>> rtl/core/nau_input_stage.sv
// Input register of the merger: holds one accepted descriptor word.
// Depends on nau_pkg.
`default_nettype none

module nau_input_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire nau_pkg::nau_unit_t in_unit,
	input  wire logic              advance,
	output logic                   valid_s1,
	output nau_pkg::nau_unit_t     unit_s1
);
	import nau_pkg::*;

	logic accept;

	// Take a new word when none is held or the held one moves on this cycle
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			unit_s1 <= in_unit;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/nau_cache.sv
// Access unit cache: flush decision, result build and cache state update.
// Depends on nau_pkg.
`default_nettype none

module nau_cache (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [1:0]         merge_mode,
	input  wire logic [7:0]         cache_limit,
	input  wire logic               advance,
	input  wire nau_pkg::nau_unit_t unit_s1,
	output nau_pkg::nau_status_t    status,
	output nau_pkg::nau_result_t    result
);
	import nau_pkg::*;

	// Cache state
	logic [8:0]  count_q;
	logic [31:0] last_dts_q;
	logic [31:0] last_pts_q;
	logic [23:0] last_size_q;
	logic [31:0] run_len_q;
	logic        any_key_q;
	logic        have_dec_q;
	logic        have_drop_q;
	logic        have_cfg_q;

	// Next state
	logic [8:0]  count_d;
	logic [31:0] last_dts_d;
	logic [31:0] last_pts_d;
	logic [23:0] last_size_d;
	logic [31:0] run_len_d;
	logic        any_key_d;
	logic        have_dec_d;
	logic        have_drop_d;
	logic        have_cfg_d;

	logic        is_empty;
	logic        over;
	logic        prefixed;
	logic        stamp_change;
	logic        flush_unit;
	logic        emit;
	logic [31:0] flush_len;
	logic [24:0] bytes;
	logic [32:0] sum;
	logic [31:0] base_len;
	logic [8:0]  base_count;

	// Flush decision
	assign is_empty     = (count_q == 9'd0);
	assign over         = (count_q > {1'b0, cache_limit});
	assign prefixed     = (merge_mode == MODE_START_CODE) || (merge_mode == MODE_LENGTH_PREFIX);
	assign stamp_change = (last_dts_q != unit_s1.decode_stamp);

	always_comb begin
		if (is_empty) begin
			flush_unit = 1'b0;
		end else if (prefixed) begin
			flush_unit = (unit_s1.droppable && !have_cfg_q)
				|| ((have_dec_q || have_drop_q)
					&& (stamp_change || unit_s1.decodable || unit_s1.config_unit))
				|| over;
		end else begin
			flush_unit = (unit_s1.prefix_length != 3'd0) || stamp_change || over;
		end
	end

	// A single unit frame keeps its own size outside length prefix mode
	assign flush_len = (count_q == 9'd1 && merge_mode != MODE_LENGTH_PREFIX)
		? {8'd0, last_size_q} : run_len_q;

	// Bytes the incoming unit adds to the frame
	always_comb begin
		unique case (merge_mode)
			MODE_START_CODE: begin
				bytes = (unit_s1.prefix_length != 3'd0) ? {1'b0, unit_s1.unit_size}
					: {1'b0, unit_s1.unit_size} + PREFIX_BYTES;
			end
			MODE_LENGTH_PREFIX: begin
				bytes = ((unit_s1.unit_size > {21'd0, unit_s1.prefix_length})
					? {1'b0, unit_s1.unit_size} - {22'd0, unit_s1.prefix_length}
					: 25'd0) + PREFIX_BYTES;
			end
			default: begin
				bytes = {1'b0, unit_s1.unit_size};
			end
		endcase
	end

	// Result word and next state
	always_comb begin
		emit        = 1'b0;
		result      = '{result_kind: KIND_MERGED, out_decode_stamp: last_dts_q,
			out_present_stamp: last_pts_q, out_key: any_key_q,
			unit_count: count_q, merged_length: flush_len};
		count_d     = count_q;
		last_dts_d  = last_dts_q;
		last_pts_d  = last_pts_q;
		last_size_d = last_size_q;
		run_len_d   = run_len_q;
		any_key_d   = any_key_q;
		have_dec_d  = have_dec_q;
		have_drop_d = have_drop_q;
		have_cfg_d  = have_cfg_q;
		base_len    = run_len_q;
		base_count  = count_q;
		sum         = 33'd0;

		if (unit_s1.command == CMD_FLUSH) begin
			// Flush request: report if anything is cached, then empty
			emit        = !is_empty;
			count_d     = 9'd0;
			run_len_d   = 32'd0;
			last_size_d = 24'd0;
			any_key_d   = 1'b0;
			have_dec_d  = 1'b0;
			have_drop_d = 1'b0;
			have_cfg_d  = 1'b0;
		end else if (!unit_s1.is_h26x) begin
			// Other codecs pass through as a key frame
			emit   = 1'b1;
			result = '{result_kind: KIND_PASS, out_decode_stamp: unit_s1.decode_stamp,
				out_present_stamp: unit_s1.present_stamp, out_key: 1'b1,
				unit_count: 9'd1, merged_length: {8'd0, unit_s1.unit_size}};
		end else begin
			emit = flush_unit;
			if (flush_unit) begin
				base_len    = 32'd0;
				base_count  = 9'd0;
				any_key_d   = 1'b0;
				have_dec_d  = 1'b0;
				have_drop_d = 1'b0;
				have_cfg_d  = 1'b0;
			end
			have_dec_d  = have_dec_d  || unit_s1.decodable;
			have_drop_d = have_drop_d || unit_s1.droppable;
			have_cfg_d  = have_cfg_d  || unit_s1.config_unit;
			any_key_d   = any_key_d   || unit_s1.key_unit;
			count_d     = (base_count == COUNT_MAX) ? base_count : base_count + 9'd1;
			last_dts_d  = unit_s1.decode_stamp;
			last_pts_d  = unit_s1.present_stamp;
			last_size_d = unit_s1.unit_size;
			sum         = {1'b0, base_len} + {8'd0, bytes};
			run_len_d   = sum[32] ? LEN_MAX : sum[31:0];
		end
	end

	assign status = '{emit: emit, cached_count: count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= 9'd0;
			last_dts_q  <= 32'd0;
			last_pts_q  <= 32'd0;
			last_size_q <= 24'd0;
			run_len_q   <= 32'd0;
			any_key_q   <= 1'b0;
			have_dec_q  <= 1'b0;
			have_drop_q <= 1'b0;
			have_cfg_q  <= 1'b0;
		end else if (advance) begin
			count_q     <= count_d;
			last_dts_q  <= last_dts_d;
			last_pts_q  <= last_pts_d;
			last_size_q <= last_size_d;
			run_len_q   <= run_len_d;
			any_key_q   <= any_key_d;
			have_dec_q  <= have_dec_d;
			have_drop_q <= have_drop_d;
			have_cfg_q  <= have_cfg_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/nau_output_stage.sv
// Result register of the merger: holds one result word until taken.
// Depends on nau_pkg.
`default_nettype none

module nau_output_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire nau_pkg::nau_result_t result_in,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output nau_pkg::nau_result_t      result_q
);
	import nau_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_in;
		end
	end

endmodule

`default_nettype wire
